/* rtl/core/tga_rle_pkg.sv */
// Shared types, codes and helpers of the Targa run-length line encoder.
// No dependencies; the command queue, front end, back end and top level import this package.
package tga_rle_pkg;

   // Width of the packet length carried in a command (packets hold at most 128 pixels)
   localparam int CMD_CNT_W = 8;

   // Depth of the command queue between front and back end
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   // Header bit that marks a run packet
   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] LEN_MASK = 8'h7F;

   // Configuration register indexes
   localparam logic CSR_RLE_ENABLE   = 1'b0;
   localparam logic CSR_ALPHA_ENABLE = 1'b1;

   // Work orders passed from the front end to the back end
   typedef enum logic [1:0] {
      CMD_PASS   = 2'd0,
      CMD_SINGLE = 2'd1,
      CMD_RAW    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [7:0]             header;
      logic [CMD_CNT_W-1:0]   count;
      logic [31:0]            key;
      logic                   line_end;
   } cmd_type;

   // One result beat as it waits for the buffer read data
   typedef struct packed {
      logic        header_valid;
      logic [7:0]  header_byte;
      logic [1:0]  pixel_count;
      logic        use_ram;
      logic        two;
      logic [31:0] key;
      logic        packet_end;
      logic        line_end;
   } beat_type;

   // Convert a stored pixel (transparency in the top byte) to the output layout
   function automatic logic [31:0] to_output(input logic [31:0] key, input logic alpha);
      logic [7:0] opacity;
      opacity = alpha ? (8'hFF - key[31:24]) : 8'h00;
      return {opacity, key[23:0]};
   endfunction

endpackage

/* rtl/core/tga_rle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tga_rle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic                                          re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, and read data held until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/tga_rle_cmdq.sv */
// Short command queue between the encoder front end and back end.
// Depends on tga_rle_pkg; takes up to two commands and gives one per cycle while popped.
module tga_rle_cmdq
   import tga_rle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push0,
   input  cmd_type cmd0,
   input  logic    push1,
   input  cmd_type cmd1,
   output logic    room,
   output logic    head_valid,
   output cmd_type head,
   input  logic    pop
);

   cmd_type                 entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic [CMDQ_PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + CMDQ_PTR_W'(push0) + CMDQ_PTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + CMDQ_PTR_W'(pop);
      count_in  = count_ff + CMDQ_CNT_W'(push0) + CMDQ_CNT_W'(push1) - CMDQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= cmd0;
      end
      if (push1) begin
         entry_ff[wr_ptr_next] <= cmd1;
      end
   end

   assign room       = (count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

/* rtl/core/tga_rle_front.sv */
// Encoder front end: accepts pixels, tracks the pending run or raw stretch,
// fills the raw pixel buffer and issues packet commands. Depends on tga_rle_pkg.
module tga_rle_front
   import tga_rle_pkg::*;
#(
   parameter int MAX_PACKET = 128,
   localparam int BANK_DEPTH = (MAX_PACKET + 1) / 2,
   localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rle_enable,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_transparency,
   input  logic               req_last_in_line,
   output logic               push0,
   output cmd_type            cmd0,
   output logic               push1,
   output cmd_type            cmd1,
   input  logic               q_room,
   input  logic               raw_done,
   output logic               even_we,
   output logic [BANK_AW-1:0] even_waddr,
   output logic [31:0]        even_wdata,
   output logic               odd_we,
   output logic [BANK_AW-1:0] odd_waddr,
   output logic [31:0]        odd_wdata
);

   localparam int CNT_W = $clog2(MAX_PACKET + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      cur_ff, cur_in;
   logic             raw_ff, raw_in;
   logic             busy_ff, busy_in;

   logic [31:0]      key;
   logic             accept;
   logic             same;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] cnt_dec;
   cmd_type          step_cmd, step2_cmd, flush_cmd;
   logic             step_v, step2_v, flush_v;
   logic             set_busy;

   function automatic cmd_type run_cmd(input logic [CNT_W-1:0] n, input logic [31:0] px);
      cmd_type c;
      logic [CMD_CNT_W-1:0] len_m1;
      len_m1   = CMD_CNT_W'(n) - 1'b1;
      c        = '0;
      c.kind   = CMD_SINGLE;
      c.header = RUN_FLAG | (len_m1 & LEN_MASK);
      c.count  = CMD_CNT_W'(n);
      c.key    = px;
      return c;
   endfunction

   function automatic cmd_type raw_cmd(input logic [CNT_W-1:0] n);
      cmd_type c;
      c       = '0;
      c.kind  = CMD_RAW;
      c.count = CMD_CNT_W'(n);
      return c;
   endfunction

   assign key     = {req_transparency, req_red, req_green, req_blue};
   assign same    = (key == cur_ff);
   assign cnt_inc = cnt_ff + 1'b1;
   assign cnt_dec = cnt_ff - 1'b1;

   // Hold new pixels when the command queue lacks room, or while a raw packet drains if this one may write the buffer
   assign req_stall = !q_room || (busy_ff && (raw_ff || (cnt_ff == ONE_CNT)));
   assign accept    = req_valid && !req_stall;

   // Classify the pixel and form commands
   always_comb begin
      cnt_in     = cnt_ff;
      cur_in     = cur_ff;
      raw_in     = raw_ff;
      step_cmd   = '0;
      step2_cmd  = '0;
      flush_cmd  = '0;
      step_v     = 1'b0;
      step2_v    = 1'b0;
      flush_v    = 1'b0;
      even_we    = 1'b0;
      odd_we     = 1'b0;
      even_waddr = '0;
      odd_waddr  = '0;
      even_wdata = key;
      odd_wdata  = key;
      push0      = 1'b0;
      push1      = 1'b0;
      cmd0       = '0;
      cmd1       = '0;

      if (accept && !rle_enable) begin
         // Uncompressed: pass the pixel and drop anything pending
         cnt_in        = '0;
         raw_in        = 1'b0;
         push0         = 1'b1;
         cmd0.kind     = CMD_PASS;
         cmd0.key      = key;
         cmd0.line_end = req_last_in_line;
      end else if (accept) begin
         if (cnt_ff == '0) begin
            cur_in = key;
            cnt_in = ONE_CNT;
            raw_in = 1'b0;
         end else if (!raw_ff && same) begin
            // Extend the run
            cnt_in = cnt_inc;
            if (cnt_inc >= MAX_CNT) begin
               step_v   = 1'b1;
               step_cmd = run_cmd(cnt_inc, cur_ff);
               cnt_in   = '0;
            end
         end else if (!raw_ff && (cnt_ff == ONE_CNT)) begin
            // Start a raw stretch with the held pixel and this one
            even_we    = 1'b1;
            even_wdata = cur_ff;
            odd_we     = 1'b1;
            cur_in     = key;
            cnt_in     = TWO_CNT;
            raw_in     = 1'b1;
            if (TWO_CNT >= MAX_CNT) begin
               step_v   = 1'b1;
               step_cmd = raw_cmd(TWO_CNT);
               cnt_in   = '0;
               raw_in   = 1'b0;
            end
         end else if (!raw_ff) begin
            // Close the run, start a new one
            step_v   = 1'b1;
            step_cmd = run_cmd(cnt_ff, cur_ff);
            cur_in   = key;
            cnt_in   = ONE_CNT;
         end else if (same) begin
            // Repeat ends the raw stretch; its last pixel opens a run
            step_v   = 1'b1;
            step_cmd = raw_cmd(cnt_dec);
            cnt_in   = TWO_CNT;
            raw_in   = 1'b0;
            if (TWO_CNT >= MAX_CNT) begin
               step2_v   = 1'b1;
               step2_cmd = run_cmd(TWO_CNT, cur_ff);
               cnt_in    = '0;
            end
         end else begin
            // Append to the raw stretch
            even_we    = !cnt_ff[0];
            odd_we     = cnt_ff[0];
            even_waddr = BANK_AW'(cnt_ff >> 1);
            odd_waddr  = BANK_AW'(cnt_ff >> 1);
            cur_in     = key;
            cnt_in     = cnt_inc;
            if (cnt_inc >= MAX_CNT) begin
               step_v   = 1'b1;
               step_cmd = raw_cmd(MAX_CNT);
               cnt_in   = '0;
               raw_in   = 1'b0;
            end
         end

         // Line end flushes what is pending
         if (req_last_in_line && (cnt_in != '0)) begin
            flush_v = 1'b1;
            if (raw_in) begin
               flush_cmd = raw_cmd(cnt_in);
            end else if (cnt_in == ONE_CNT) begin
               flush_cmd        = '0;
               flush_cmd.kind   = CMD_SINGLE;
               flush_cmd.count  = CMD_CNT_W'(1);
               flush_cmd.key    = cur_in;
            end else begin
               flush_cmd = run_cmd(cnt_in, cur_in);
            end
            cnt_in = '0;
            raw_in = 1'b0;
         end

         // Pack commands into the two slots, line end on the later one
         push0 = step_v || flush_v;
         cmd0  = step_v ? step_cmd : flush_cmd;
         push1 = step2_v || (step_v && flush_v);
         cmd1  = step2_v ? step2_cmd : flush_cmd;
         if (push1) begin
            cmd1.line_end = req_last_in_line;
         end else begin
            cmd0.line_end = req_last_in_line;
         end
      end
   end

   // Track a raw packet that still reads the buffer
   assign set_busy = (push0 && (cmd0.kind == CMD_RAW)) || (push1 && (cmd1.kind == CMD_RAW));
   assign busy_in  = set_busy || (busy_ff && !raw_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         cur_ff  <= '0;
         raw_ff  <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         cur_ff  <= cur_in;
         raw_ff  <= raw_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* rtl/core/tga_rle_back.sv */
// Encoder back end: turns commands into result items, reading raw pixels
// two at a time from the buffer banks. Depends on tga_rle_pkg.
module tga_rle_back
   import tga_rle_pkg::*;
#(
   parameter int MAX_PACKET = 128,
   localparam int BANK_DEPTH = (MAX_PACKET + 1) / 2,
   localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               alpha_enable,
   input  logic               head_valid,
   input  cmd_type            head,
   output logic               pop,
   output logic               raw_done,
   output logic               rd_en,
   output logic [BANK_AW-1:0] rd_addr,
   input  logic [31:0]        even_rdata,
   input  logic [31:0]        odd_rdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_header_valid,
   output logic [7:0]         rsp_header_byte,
   output logic [1:0]         rsp_pixel_count,
   output logic [31:0]        rsp_first_pixel,
   output logic [31:0]        rsp_second_pixel,
   output logic               rsp_packet_end,
   output logic               rsp_line_end
);

   logic [CMD_CNT_W-1:0] off_ff, off_in;
   logic                 s1_valid_ff, s1_valid_in;
   beat_type             s1_ff, s1_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_hv_ff;
   logic [7:0]           out_hdr_ff;
   logic [1:0]           out_cnt_ff;
   logic [31:0]          out_first_ff, out_second_ff;
   logic                 out_pend_ff, out_line_ff;

   logic                 out_free;
   logic                 s1_adv;
   logic                 issue;
   logic                 is_raw;
   logic [CMD_CNT_W-1:0] remain;
   logic                 two;
   logic                 final_beat;
   logic [CMD_CNT_W-1:0] len_m1;
   logic [31:0]          first_key;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign issue    = head_valid && (!s1_valid_ff || s1_adv);

   assign is_raw     = (head.kind == CMD_RAW);
   assign remain     = head.count - off_ff;
   assign two        = is_raw && (remain >= CMD_CNT_W'(2));
   assign final_beat = !is_raw || (remain <= CMD_CNT_W'(2));
   assign len_m1     = head.count - 1'b1;

   assign pop      = issue && final_beat;
   assign raw_done = pop && is_raw;
   assign rd_en    = issue && is_raw;
   assign rd_addr  = BANK_AW'(off_ff >> 1);

   // Form the next beat from the queue head
   always_comb begin
      s1_in             = '0;
      s1_in.key         = head.key;
      s1_in.use_ram     = is_raw;
      s1_in.two         = two;
      s1_in.pixel_count = two ? 2'd2 : 2'd1;
      s1_in.packet_end  = (head.kind != CMD_PASS) && final_beat;
      s1_in.line_end    = head.line_end && final_beat;
      case (head.kind)
         CMD_PASS: begin
            s1_in.header_valid = 1'b0;
            s1_in.header_byte  = 8'h00;
         end
         CMD_SINGLE: begin
            s1_in.header_valid = 1'b1;
            s1_in.header_byte  = head.header;
         end
         CMD_RAW: begin
            s1_in.header_valid = (off_ff == '0);
            s1_in.header_byte  = (off_ff == '0) ? (len_m1 & LEN_MASK) : 8'h00;
         end
         default: begin
            s1_in.header_valid = 1'b0;
            s1_in.header_byte  = 8'h00;
         end
      endcase
   end

   // Advance the position within a raw packet
   always_comb begin
      off_in = off_ff;
      if (pop) begin
         off_in = '0;
      end else if (issue) begin
         off_in = off_ff + CMD_CNT_W'(2);
      end
   end

   assign s1_valid_in  = issue || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && rsp_stall);
   assign first_key    = s1_ff.use_ram ? even_rdata : s1_ff.key;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold beat fields; load the output register when it frees up
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         out_hv_ff     <= s1_ff.header_valid;
         out_hdr_ff    <= s1_ff.header_byte;
         out_cnt_ff    <= s1_ff.pixel_count;
         out_first_ff  <= to_output(first_key, alpha_enable);
         out_second_ff <= s1_ff.two ? to_output(odd_rdata, alpha_enable) : 32'h0;
         out_pend_ff   <= s1_ff.packet_end;
         out_line_ff   <= s1_ff.line_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_header_valid = out_hv_ff;
   assign rsp_header_byte  = out_hdr_ff;
   assign rsp_pixel_count  = out_cnt_ff;
   assign rsp_first_pixel  = out_first_ff;
   assign rsp_second_pixel = out_second_ff;
   assign rsp_packet_end   = out_pend_ff;
   assign rsp_line_end     = out_line_ff;

endmodule

/* rtl/core/tga_rle_line_encoder_top.sv */
// Targa run-length line encoder, top level: CSRs, front end, command queue,
// raw pixel buffer banks and back end. Depends on tga_rle_pkg and all submodules.
//
// Pixels enter one per item with a last-of-line mark and leave as Targa packet
// items, each with an optional header byte and one or two pixels. The front end
// takes one pixel per cycle while it has two free command queue slots; the back
// end emits one item per cycle while the output is not stalled, so a raw packet
// of n pixels gives ceil(n/2) items and a run packet one. Raw pixels sit in an
// even and an odd buffer bank; while a raw packet is still being read out, a
// pixel that would write the buffer waits. Uncompressed mode passes one pixel per
// cycle while the output does not stall. Results pass from the queue through the
// beat register and the output register.
module tga_rle_line_encoder_top
   import tga_rle_pkg::*;
#(
   parameter int MAX_PACKET = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_transparency,
   input  logic        req_last_in_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_header_valid,
   output logic [7:0]  rsp_header_byte,
   output logic [1:0]  rsp_pixel_count,
   output logic [31:0] rsp_first_pixel,
   output logic [31:0] rsp_second_pixel,
   output logic        rsp_packet_end,
   output logic        rsp_line_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   localparam int BANK_DEPTH = (MAX_PACKET + 1) / 2;
   localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic               rle_ff, rle_in;
   logic               alpha_ff, alpha_in;

   logic               push0, push1, q_room, head_valid, pop, raw_done;
   cmd_type            cmd0, cmd1, head;
   logic               even_we, odd_we, rd_en;
   logic [BANK_AW-1:0] even_waddr, odd_waddr, rd_addr;
   logic [31:0]        even_wdata, odd_wdata, even_rdata, odd_rdata;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      rle_in   = rle_ff;
      alpha_in = alpha_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RLE_ENABLE:   rle_in   = csr_wdata;
            CSR_ALPHA_ENABLE: alpha_in = csr_wdata;
            default: begin
               rle_in   = rle_ff;
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_ff   <= 1'b1;
         alpha_ff <= 1'b0;
      end else begin
         rle_ff   <= rle_in;
         alpha_ff <= alpha_in;
      end
   end

   tga_rle_front #(.MAX_PACKET(MAX_PACKET)) u_front (
      .clock            (clock),
      .reset            (reset),
      .rle_enable       (rle_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_transparency (req_transparency),
      .req_last_in_line (req_last_in_line),
      .push0            (push0),
      .cmd0             (cmd0),
      .push1            (push1),
      .cmd1             (cmd1),
      .q_room           (q_room),
      .raw_done         (raw_done),
      .even_we          (even_we),
      .even_waddr       (even_waddr),
      .even_wdata       (even_wdata),
      .odd_we           (odd_we),
      .odd_waddr        (odd_waddr),
      .odd_wdata        (odd_wdata)
   );

   tga_rle_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .cmd0       (cmd0),
      .push1      (push1),
      .cmd1       (cmd1),
      .room       (q_room),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // Even-indexed raw pixels
   tga_rle_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_even_bank (
      .clock (clock),
      .we    (even_we),
      .waddr (even_waddr),
      .wdata (even_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (even_rdata)
   );

   // Odd-indexed raw pixels
   tga_rle_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_odd_bank (
      .clock (clock),
      .we    (odd_we),
      .waddr (odd_waddr),
      .wdata (odd_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (odd_rdata)
   );

   tga_rle_back #(.MAX_PACKET(MAX_PACKET)) u_back (
      .clock            (clock),
      .reset            (reset),
      .alpha_enable     (alpha_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .raw_done         (raw_done),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .even_rdata       (even_rdata),
      .odd_rdata        (odd_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_header_valid (rsp_header_valid),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_first_pixel  (rsp_first_pixel),
      .rsp_second_pixel (rsp_second_pixel),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_line_end     (rsp_line_end)
   );

endmodule

/* rtl/core/tga_rle_checker.sv */
// Port-level checks on the encoder's result channel, and the bind that
// attaches them to tga_rle_line_encoder_top. Depends on the top level's ports.
module tga_rle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_header_valid,
   input logic [7:0]  rsp_header_byte,
   input logic [1:0]  rsp_pixel_count,
   input logic        rsp_packet_end
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Every item carries one or two pixels
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_count == 2'd1) || (rsp_pixel_count == 2'd2))
      else $error("bad pixel count");

   // No header, no header byte
   a_no_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_header_valid |-> rsp_header_byte == 8'h00)
      else $error("header byte without header");

   // A run packet is one item with one pixel
   a_run_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_valid && rsp_header_byte[7]
         |-> (rsp_pixel_count == 2'd1) && rsp_packet_end)
      else $error("malformed run packet");

endmodule

bind tga_rle_line_encoder_top tga_rle_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_header_valid (rsp_header_valid),
   .rsp_header_byte  (rsp_header_byte),
   .rsp_pixel_count  (rsp_pixel_count),
   .rsp_packet_end   (rsp_packet_end)
);
